// ===== hdl/iirdf1_pkg.sv =====
`default_nettype none

package iirdf1_pkg;

  // Sample and coefficient formats
  localparam int DATA_W     = 16;  // Q1.15 samples
  localparam int COEF_W     = 16;  // Q2.14 coefficients
  localparam int PROD_W     = DATA_W + COEF_W;

  // Tap layout: feedforward taps first, then the feedback taps
  localparam int NUM_FF     = 5;
  localparam int NUM_FB     = 2;
  localparam int NUM_REGS   = NUM_FF + NUM_FB;
  localparam int IN_DEPTH   = NUM_FF - 1;
  localparam int OUT_DEPTH  = NUM_FB;
  localparam int TAP_W      = $clog2(NUM_REGS + 1);
  localparam int IDX_W      = TAP_W;

  // Seven Q3.29 products summed need 35 bits; one guard bit on top
  localparam int ACC_W      = PROD_W + $clog2(NUM_REGS) + 1;
  localparam int FRAC_SHIFT = 14;
  localparam int Q_W        = ACC_W - FRAC_SHIFT;
  localparam logic [ACC_W-1:0] ROUND_BIAS = ACC_W'(1) << (FRAC_SHIFT - 1);

  // Register indexes
  localparam logic [IDX_W-1:0] REG_FF_COEF_0 = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_FB_COEF_1 = IDX_W'(NUM_FF);
  localparam logic [IDX_W-1:0] REG_FB_COEF_2 = IDX_W'(NUM_FF + 1);

  // Coefficient reset values, by register index
  localparam logic [COEF_W-1:0] COEF_RESET [NUM_REGS] = '{
    16'd1638, 16'd2458, 16'd8192, 16'd2458, 16'd1638, 16'hE000, 16'd4096
  };

  // Control from the sequencer to the multiply-accumulate unit
  typedef struct packed {
    logic clr;  // zero the accumulator
    logic en;   // issue one product this cycle
    logic sub;  // product is subtracted (feedback tap)
  } mac_ctl_t;

endpackage

`default_nettype wire

// ===== hdl/iirdf1_mac.sv =====
`default_nettype none

module iirdf1_mac (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  iirdf1_pkg::mac_ctl_t                  ctl_i,
  input  wire  signed [iirdf1_pkg::COEF_W-1:0]  coef_i,
  input  wire  signed [iirdf1_pkg::DATA_W-1:0]  data_i,
  output logic signed [iirdf1_pkg::ACC_W-1:0]   acc_o
);

  logic signed [iirdf1_pkg::PROD_W-1:0] prod_q;
  logic                                 vld_q;
  logic                                 sub_q;
  logic signed [iirdf1_pkg::ACC_W-1:0]  acc_q;
  logic signed [iirdf1_pkg::ACC_W-1:0]  prod_ext;

  assign prod_ext = iirdf1_pkg::ACC_W'(prod_q);

  // Product register, then accumulate in the next cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_q <= '0;
      vld_q  <= 1'b0;
      sub_q  <= 1'b0;
      acc_q  <= '0;
    end else if (ctl_i.clr) begin
      vld_q  <= 1'b0;
      acc_q  <= '0;
    end else begin
      prod_q <= coef_i * data_i;
      vld_q  <= ctl_i.en;
      sub_q  <= ctl_i.sub;
      if (vld_q) begin
        acc_q <= sub_q ? acc_q - prod_ext : acc_q + prod_ext;
      end
    end
  end

  assign acc_o = acc_q;

endmodule

`default_nettype wire

// ===== hdl/iirdf1_coef.sv =====
`default_nettype none

module iirdf1_coef (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  cfg_we_i,
  input  wire  [iirdf1_pkg::IDX_W-1:0]         cfg_idx_i,
  input  wire  [iirdf1_pkg::COEF_W-1:0]        cfg_data_i,
  input  wire  [iirdf1_pkg::TAP_W-1:0]         tap_i,
  output logic signed [iirdf1_pkg::COEF_W-1:0] coef_o
);

  logic [iirdf1_pkg::COEF_W-1:0] coef_q [iirdf1_pkg::NUM_REGS];

  // Register file; writes past the last index are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < iirdf1_pkg::NUM_REGS; i++) begin
        coef_q[i] <= iirdf1_pkg::COEF_RESET[i];
      end
    end else if (cfg_we_i && (cfg_idx_i < iirdf1_pkg::IDX_W'(iirdf1_pkg::NUM_REGS))) begin
      coef_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  // Coefficient for the tap being processed
  always_comb begin
    if (tap_i < iirdf1_pkg::TAP_W'(iirdf1_pkg::NUM_REGS)) begin
      coef_o = $signed(coef_q[tap_i]);
    end else begin
      coef_o = '0;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/iir_filter_direct_form_one.sv =====
// Direct-form-I IIR filter, one Q1.15 output word per Q1.15 input word.
// The output is b0*x[n]+..+b4*x[n-4] - a1*y[n-1] - a2*y[n-2] with Q2.14
// coefficients, rounded half up to Q1.15 and saturated; tuser on the output
// flags saturation, tuser on the input clears both histories first. All seven
// products go through one 16x16 multiplier with a registered product and a
// 36-bit accumulator, one tap per cycle. After the input accept a sample steps
// through the seven taps, a drain state that adds the last product and a done
// state that loads the output register. The next input word is taken in the
// cycle after that load; a full output register holds the last step and stalls
// the input until the word is taken. Coefficients are to be written by the user
// through cfg_we_i/cfg_idx_i/cfg_data_i while the filter is idle; the block
// itself does not enforce this.
`default_nettype none

module iir_filter_direct_form_one (
  input  wire         clk_i,
  input  wire         rst_ni,
  // configuration write port
  input  wire         cfg_we_i,
  input  wire  [2:0]  cfg_idx_i,
  input  wire  [15:0] cfg_data_i,
  // input stream
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [15:0] s_axis_tdata,   // [15:0] sample_in
  input  wire         s_axis_tuser,   // [0] stream_start
  // output stream
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] sample_out
  output logic        m_axis_tuser    // [0] clipped
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_DONE
  } state_e;

  localparam int DW = iirdf1_pkg::DATA_W;
  localparam int TW = iirdf1_pkg::TAP_W;

  state_e                   state_q;
  logic [TW-1:0]            tap_q;
  logic signed [DW-1:0]     x_q;
  logic [DW-1:0]            in_hist_q  [iirdf1_pkg::IN_DEPTH];
  logic [DW-1:0]            out_hist_q [iirdf1_pkg::OUT_DEPTH];
  logic                     m_tvalid_q;
  logic [DW-1:0]            m_tdata_q;
  logic                     m_tuser_q;

  logic                     in_fire;
  logic                     out_free;
  iirdf1_pkg::mac_ctl_t     mac_ctl;
  logic signed [iirdf1_pkg::COEF_W-1:0] coef;
  logic signed [DW-1:0]     operand;
  logic signed [iirdf1_pkg::ACC_W-1:0]  acc;
  logic [TW-1:0]            ff_idx;
  logic [TW-1:0]            fb_idx;
  logic [iirdf1_pkg::ACC_W-1:0] biased;
  logic [iirdf1_pkg::Q_W-1:0]   q;
  logic                     fits;
  logic [DW-1:0]            y;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_tvalid_q || m_axis_tready;

  // Operand for the current tap: new sample, input history, output history
  assign ff_idx = tap_q - TW'(1);
  assign fb_idx = tap_q - TW'(iirdf1_pkg::NUM_FF);
  always_comb begin
    if (tap_q == iirdf1_pkg::REG_FF_COEF_0) begin
      operand = x_q;
    end else if (tap_q < iirdf1_pkg::REG_FB_COEF_1) begin
      operand = $signed(in_hist_q[ff_idx[$clog2(iirdf1_pkg::IN_DEPTH)-1:0]]);
    end else begin
      operand = $signed(out_hist_q[fb_idx[$clog2(iirdf1_pkg::OUT_DEPTH)-1:0]]);
    end
  end

  assign mac_ctl.clr = in_fire;
  assign mac_ctl.en  = (state_q == ST_MAC);
  assign mac_ctl.sub = (tap_q >= iirdf1_pkg::REG_FB_COEF_1);

  iirdf1_coef u_coef (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .tap_i      (tap_q),
    .coef_o     (coef)
  );

  iirdf1_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mac_ctl),
    .coef_i (coef),
    .data_i (operand),
    .acc_o  (acc)
  );

  // Round half up to Q1.15, then saturate
  assign biased = acc + iirdf1_pkg::ROUND_BIAS;
  assign q      = biased[iirdf1_pkg::ACC_W-1:iirdf1_pkg::FRAC_SHIFT];
  assign fits   = (q[iirdf1_pkg::Q_W-1:DW-1] == '0) || (q[iirdf1_pkg::Q_W-1:DW-1] == '1);
  always_comb begin
    if (fits) begin
      y = q[DW-1:0];
    end else if (q[iirdf1_pkg::Q_W-1]) begin
      y = {1'b1, {(DW-1){1'b0}}};
    end else begin
      y = {1'b0, {(DW-1){1'b1}}};
    end
  end

  // Sequencer, histories and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      tap_q      <= '0;
      x_q        <= '0;
      m_tvalid_q <= 1'b0;
      m_tdata_q  <= '0;
      m_tuser_q  <= 1'b0;
      for (int i = 0; i < iirdf1_pkg::IN_DEPTH; i++) in_hist_q[i] <= '0;
      for (int i = 0; i < iirdf1_pkg::OUT_DEPTH; i++) out_hist_q[i] <= '0;
    end else begin
      // in the last step a taken word is replaced by the new one below
      if (m_tvalid_q && m_axis_tready && (state_q != ST_DONE)) begin
        m_tvalid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            x_q     <= $signed(s_axis_tdata);
            tap_q   <= '0;
            state_q <= ST_MAC;
            if (s_axis_tuser) begin
              for (int i = 0; i < iirdf1_pkg::IN_DEPTH; i++) in_hist_q[i] <= '0;
              for (int i = 0; i < iirdf1_pkg::OUT_DEPTH; i++) out_hist_q[i] <= '0;
            end
          end
        end
        ST_MAC: begin
          tap_q <= tap_q + TW'(1);
          if (tap_q == iirdf1_pkg::REG_FB_COEF_2) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          // wait for the output register before committing the sample
          if (out_free) begin
            m_tvalid_q <= 1'b1;
            m_tdata_q  <= y;
            m_tuser_q  <= !fits;
            for (int i = iirdf1_pkg::IN_DEPTH - 1; i > 0; i--) in_hist_q[i] <= in_hist_q[i-1];
            in_hist_q[0] <= x_q;
            for (int i = iirdf1_pkg::OUT_DEPTH - 1; i > 0; i--) out_hist_q[i] <= out_hist_q[i-1];
            out_hist_q[0] <= y;
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = m_tdata_q;
  assign m_axis_tuser  = m_tuser_q;

endmodule

`default_nettype wire

// ===== hdl/iirdf1_checker.sv =====
`default_nettype none

module iirdf1_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        s_axis_tvalid,
  input wire        s_axis_tready,
  input wire        m_axis_tvalid,
  input wire        m_axis_tready,
  input wire [15:0] m_axis_tdata,
  input wire        m_axis_tuser
);

  // stalled output word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("output word changed while stalled");

  // one sample in flight: busy right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while a sample is in flight");

  // a result needs the full tap sequence, never the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
    else $error("output word too early");

  // clipped words sit on a rail
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 16'h7fff || m_axis_tdata == 16'h8000)
    else $error("clipped word not at full scale");

endmodule

bind iir_filter_direct_form_one iirdf1_checker u_iirdf1_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// ===== tb/sv/iir_df1_response_check.sv =====
`default_nettype none

// Watches the configuration port and both stream channels, keeps its own copy
// of the coefficients and the sample histories, predicts each output word and
// compares it field by field with what the filter delivers.
module iir_df1_response_check (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_we_i,
  input  wire  [2:0]  cfg_idx_i,
  input  wire  [15:0] cfg_data_i,
  input  wire         s_axis_tvalid,
  input  wire         s_axis_tready,
  input  wire  [15:0] s_axis_tdata,   // [15:0] sample_in
  input  wire         s_axis_tuser,   // [0] stream_start
  input  wire         m_axis_tvalid,
  input  wire         m_axis_tready,
  input  wire  [15:0] m_axis_tdata,   // [15:0] sample_out
  input  wire         m_axis_tuser,   // [0] clipped
  output int          fail_count_o,
  output int          pending_o,
  output int          words_checked_o,
  output int          clipped_seen_o
);

  typedef struct packed {
    logic [iirdf1_pkg::DATA_W-1:0] sample;
    logic                          clip;
  } out_word_t;

  // Filter state as the predictor sees it
  logic signed [iirdf1_pkg::COEF_W-1:0] coef   [iirdf1_pkg::NUM_REGS];
  logic signed [iirdf1_pkg::DATA_W-1:0] x_hist [iirdf1_pkg::IN_DEPTH];
  logic signed [iirdf1_pkg::DATA_W-1:0] y_hist [iirdf1_pkg::OUT_DEPTH];

  out_word_t expected_words [$];
  int        fails;
  int        checked;
  int        clips;

  // One filter step: optional history clear, 7-tap sum, round half up, saturate
  function automatic out_word_t filter_sample(
      input logic signed [iirdf1_pkg::DATA_W-1:0] x,
      input logic start);
    longint    acc;
    longint    q;
    out_word_t w;
    int        k;
    if (start) begin
      foreach (x_hist[i]) x_hist[i] = '0;
      foreach (y_hist[i]) y_hist[i] = '0;
    end
    acc = longint'(coef[0]) * longint'(x);
    for (k = 0; k < iirdf1_pkg::IN_DEPTH; k++)
      acc += longint'(coef[k + 1]) * longint'(x_hist[k]);
    for (k = 0; k < iirdf1_pkg::OUT_DEPTH; k++)
      acc -= longint'(coef[iirdf1_pkg::NUM_FF + k]) * longint'(y_hist[k]);
    q = (acc + 64'sd8192) >>> iirdf1_pkg::FRAC_SHIFT;
    w.clip = 1'b1;
    if (q > 32767) q = 32767;
    else if (q < -32768) q = -32768;
    else w.clip = 1'b0;
    w.sample = q[iirdf1_pkg::DATA_W-1:0];
    for (k = iirdf1_pkg::IN_DEPTH - 1; k > 0; k--) x_hist[k] = x_hist[k - 1];
    x_hist[0] = x;
    for (k = iirdf1_pkg::OUT_DEPTH - 1; k > 0; k--) y_hist[k] = y_hist[k - 1];
    y_hist[0] = w.sample;
    return w;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t got;
    out_word_t want;
    if (!rst_ni) begin
      foreach (coef[i]) coef[i] = iirdf1_pkg::COEF_RESET[i];
      foreach (x_hist[i]) x_hist[i] = '0;
      foreach (y_hist[i]) y_hist[i] = '0;
      expected_words.delete();
      fails   = 0;
      checked = 0;
      clips   = 0;
    end else begin
      // coefficient writes; out-of-range indexes are dropped
      if (cfg_we_i && cfg_idx_i < iirdf1_pkg::NUM_REGS)
        coef[cfg_idx_i] = cfg_data_i;

      if (s_axis_tvalid && s_axis_tready)
        expected_words.push_back(filter_sample(s_axis_tdata, s_axis_tuser));

      if (m_axis_tvalid && m_axis_tready) begin
        got.sample = m_axis_tdata;
        got.clip   = m_axis_tuser;
        if (expected_words.size() == 0) begin
          $error("unexpected output word: sample_out=%0d clipped=%0b",
                 $signed(got.sample), got.clip);
          fails++;
        end else begin
          want = expected_words.pop_front();
          checked++;
          if (got.clip) clips++;
          if (got.sample !== want.sample) begin
            $error("sample_out mismatch: expected %0d, actual %0d",
                   $signed(want.sample), $signed(got.sample));
            fails++;
          end
          if (got.clip !== want.clip) begin
            $error("clipped mismatch: expected %0b, actual %0b", want.clip, got.clip);
            fails++;
          end
        end
      end
    end
    fail_count_o    <= fails;
    pending_o       <= expected_words.size();
    words_checked_o <= checked;
    clipped_seen_o  <= clips;
  end

endmodule

`default_nettype wire

// ===== tb/sv/tb_iir_filter_direct_form_one.sv =====
`default_nettype none

module tb_iir_filter_direct_form_one;

  localparam logic [iirdf1_pkg::IDX_W-1:0] REG_UNUSED =
    iirdf1_pkg::IDX_W'(iirdf1_pkg::NUM_REGS);
  localparam int DRAIN_CYCLES = 16;
  localparam int HOLD_CYCLES  = 150;
  localparam int RANDOM_PER_SET = 150;

  // Directed words under the reset coefficients; a stream start on 0, 5 and 10
  localparam logic [15:0] EDGE_SAMPLES [16] = '{
    16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
    16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
    16'h0000, 16'hFFFF, 16'h0001, 16'h5555, 16'hAAAA, 16'h0000
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;   // [15:0] sample_in
  logic        s_axis_tuser = 1'b0; // [0] stream_start
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // [15:0] sample_out
  logic        m_axis_tuser;        // [0] clipped

  int fail_count;
  int pending;
  int words_checked;
  int clipped_seen;

  int words_sent;
  int starts_sent;
  int coef_sets;
  int send_idle_pct = 33;
  int recv_idle_pct = 46;

  iir_filter_direct_form_one uut (
    .clk_i, .rst_ni,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  iir_df1_response_check u_response_check (
    .clk_i, .rst_ni,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .words_checked_o (words_checked),
    .clipped_seen_o  (clipped_seen)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Hard stop in case the filter hangs
  initial begin
    #(12 * 400000);
    $display("CHECK FAILED");
    $finish;
  end

  // Output side: random back-pressure, plus one long hold to fill the pipe
  initial begin
    int hold_left;
    bit held;
    hold_left = 0;
    held = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!held && words_checked >= 200) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Offer one word, with random gaps before it; returns after the accept edge
  task automatic send_word(input logic [15:0] x, input logic start);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= x;
    s_axis_tuser  <= start;
    do @(posedge clk_i); while (!s_axis_tready);
    words_sent++;
    if (start) starts_sent++;
    // idle pattern: receiver-heavy, then sender-heavy, then none
    if (words_sent == 540) begin
      send_idle_pct = 46;
      recv_idle_pct = 33;
    end else if (words_sent == 1080) begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  endtask

  // Let every expected word come back before touching the coefficients
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Write all seven coefficients back to back, then one ignored index
  task automatic program_coefs(input logic [15:0] c [iirdf1_pkg::NUM_REGS]);
    for (int i = 0; i < iirdf1_pkg::NUM_REGS; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= iirdf1_pkg::REG_FF_COEF_0 + iirdf1_pkg::IDX_W'(i);
      cfg_data_i <= c[i];
      @(posedge clk_i);
    end
    cfg_idx_i  <= REG_UNUSED;
    cfg_data_i <= 16'($urandom);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    coef_sets++;
  endtask

  function automatic logic [15:0] pick_coef();
    case ($urandom_range(3))
      0:       return 16'($urandom);
      1:       return 16'($urandom_range(4096)) - 16'd2048;
      2:       return $urandom_range(1) ? 16'h7FFF : 16'h8000;
      default: return 16'($urandom_range(16384)) - 16'd8192;
    endcase
  endfunction

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(7))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2, 3:    return 16'($urandom_range(2048)) - 16'd1024;
      default: return 16'($urandom);
    endcase
  endfunction

  // Random words in runs that each open with a stream start, plus stray starts
  task automatic send_runs(input int count);
    int run_left;
    logic start;
    run_left = 0;
    repeat (count) begin
      start = 1'b0;
      if (run_left == 0) begin
        run_left = $urandom_range(60, 1);
        start = 1'b1;
      end else if ($urandom_range(99) < 2) begin
        start = 1'b1;
      end
      run_left--;
      send_word(pick_sample(), start);
    end
  endtask

  initial begin
    logic [15:0] c [iirdf1_pkg::NUM_REGS];
    words_sent  = 0;
    starts_sent = 0;
    coef_sets   = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset coefficients: extremes, steady full scale, stream starts
    foreach (EDGE_SAMPLES[i])
      send_word(EDGE_SAMPLES[i], i == 0 || i == 5 || i == 10);
    send_runs(RANDOM_PER_SET);
    wait_drained();

    // b0 = 0.5 alone: odd inputs land exactly on the rounding half
    foreach (c[i]) c[i] = '0;
    c[0] = 16'd8192;
    program_coefs(c);
    send_word(16'h0001, 1'b1);
    send_word(16'hFFFF, 1'b0);
    send_word(16'h0003, 1'b0);
    send_word(16'hFFFD, 1'b0);
    send_word(16'h7FFF, 1'b0);
    send_word(16'h8000, 1'b0);
    send_runs(100);
    wait_drained();

    // Largest gain with the strongest feedback: heavy clipping
    foreach (c[i]) c[i] = (i < iirdf1_pkg::NUM_FF) ? 16'h7FFF : 16'h8000;
    program_coefs(c);
    send_runs(RANDOM_PER_SET);
    wait_drained();

    // The opposite corner
    foreach (c[i]) c[i] = (i < iirdf1_pkg::NUM_FF) ? 16'h8000 : 16'h7FFF;
    program_coefs(c);
    send_runs(RANDOM_PER_SET);
    wait_drained();

    // Random coefficient sets
    repeat (7) begin
      foreach (c[i]) c[i] = pick_coef();
      program_coefs(c);
      send_runs(RANDOM_PER_SET);
      wait_drained();
    end

    $display("Filtered %0d words (%0d stream starts) over %0d coefficient sets;",
             words_sent, starts_sent, coef_sets + 1);
    $display("checked %0d output words, %0d of them saturated.",
             words_checked, clipped_seen);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
